>>> rtl/core/atint_pkg.sv
package atint_pkg;

   localparam int VALUE_W    = 32;
   localparam int NUM_COLS   = 5;
   localparam int COL_W      = 3;
   localparam int ROW_IN_W   = 6;
   localparam int CSR_W      = 7;
   localparam int REGION_W   = 2;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int DIV_CYCLES = VALUE_W / 2;
   localparam int STEP_W     = 4;

   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(NUM_COLS - 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_CYCLES - 1);

   localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
   localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
   localparam logic [REGION_W-1:0] REGION_ABOVE  = 2'd2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [CSR_W-1:0] ROWS_RESET = 7'd1;

   typedef logic [NUM_COLS-1:0][VALUE_W-1:0] atint_row_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_LO,
      ST_RD_HI,
      ST_CAP_HI,
      ST_CLAMP,
      ST_DIFF,
      ST_MUL,
      ST_DIV,
      ST_STORE,
      ST_FINISH
   } atint_state_type;

   typedef struct packed {
      logic             load;
      logic             start;
      logic             scan;
      logic             rd_hi;
      logic             cap_lo;
      logic             cap_hi;
      logic             cap_clamp;
      logic             diff;
      logic             mul;
      logic             div_step;
      logic             store;
      logic             out_load;
      logic [COL_W-1:0] col;
   } atint_cmd_type;

   typedef struct packed {
      logic hit;
      logic exhausted;
      logic clamp;
      logic rsp_busy;
   } atint_sts_type;

endpackage

>>> rtl/core/atmosphere_table_interpolation_unit.sv
// channel   direction  ports                                    transfer when
// req       in         req_kind/row/altitude/value_a..e         req_valid && !req_stall
// rsp       out        rsp_prop_a..e, rsp_region                rsp_valid && !rsp_stall
// csr       in         csr_wr_data (rows_in_use)                csr_wr_en
//
// a load produces no response; the block stays ready
// a query scans the rows (one row per cycle from the key memory) up to the first larger key or the last row,
//   then returns the clamped end row or interpolates between the two bracketing rows:
//   each column uses one multiply and a radix-4 restoring divider
// one query at a time; req_stall is high while a query is at work
// a finished response waits in the output register; loads are still taken meanwhile
// synchronous reset clears control state and sets rows_in_use to one; table contents
//   are undefined until loaded, no clearing pass
module atmosphere_table_interpolation_unit
   import atint_pkg::*;
#(
   parameter int TABLE_ROWS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_kind,
   input  logic [ROW_IN_W-1:0]        req_row,
   input  logic signed [VALUE_W-1:0]  req_altitude,
   input  logic signed [VALUE_W-1:0]  req_value_a,
   input  logic signed [VALUE_W-1:0]  req_value_b,
   input  logic signed [VALUE_W-1:0]  req_value_c,
   input  logic signed [VALUE_W-1:0]  req_value_d,
   input  logic signed [VALUE_W-1:0]  req_value_e,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_prop_a,
   output logic signed [VALUE_W-1:0]  rsp_prop_b,
   output logic signed [VALUE_W-1:0]  rsp_prop_c,
   output logic signed [VALUE_W-1:0]  rsp_prop_d,
   output logic signed [VALUE_W-1:0]  rsp_prop_e,
   output logic [REGION_W-1:0]        rsp_region,
   // configuration write port
   input  logic                       csr_wr_en,
   input  logic [CSR_W-1:0]           csr_wr_data
);

   // command and status between sequencer and datapath
   atint_cmd_type cmd;
   atint_sts_type sts;

   // sequencer: scan, fetch of the bracketing rows, per-column multiply and divide
   atint_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .sts       (sts),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   // datapath: key and property memories, comparator, multiplier, divider,
   // output register
   atint_dp #(
      .TABLE_ROWS (TABLE_ROWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_row      (req_row),
      .req_altitude (req_altitude),
      .req_value_a  (req_value_a),
      .req_value_b  (req_value_b),
      .req_value_c  (req_value_c),
      .req_value_d  (req_value_d),
      .req_value_e  (req_value_e),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_prop_a   (rsp_prop_a),
      .rsp_prop_b   (rsp_prop_b),
      .rsp_prop_c   (rsp_prop_c),
      .rsp_prop_d   (rsp_prop_d),
      .rsp_prop_e   (rsp_prop_e),
      .rsp_region   (rsp_region)
   );

endmodule

>>> rtl/core/atint_ram.sv
module atint_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/atint_ctrl.sv
module atint_ctrl
   import atint_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_kind,
   input  atint_sts_type sts,
   output atint_cmd_type cmd,
   output logic          req_stall
);

   atint_state_type   state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      col_ff  <= col_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.col  = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  cmd.load = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit || sts.exhausted) begin
               state_in = ST_RD_LO;
            end
         end
         ST_RD_LO: begin
            state_in = sts.clamp ? ST_CLAMP : ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.rd_hi  = 1'b1;
            cmd.cap_lo = 1'b1;
            state_in   = ST_CAP_HI;
         end
         ST_CAP_HI: begin
            cmd.cap_hi = 1'b1;
            col_in     = '0;
            state_in   = ST_DIFF;
         end
         ST_CLAMP: begin
            cmd.cap_clamp = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (col_ff == LAST_COL) begin
               state_in = ST_FINISH;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_DIFF;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/atint_dp.sv
module atint_dp
   import atint_pkg::*;
#(
   parameter int TABLE_ROWS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  atint_cmd_type              cmd,
   output atint_sts_type              sts,
   input  logic [ROW_IN_W-1:0]        req_row,
   input  logic signed [VALUE_W-1:0]  req_altitude,
   input  logic signed [VALUE_W-1:0]  req_value_a,
   input  logic signed [VALUE_W-1:0]  req_value_b,
   input  logic signed [VALUE_W-1:0]  req_value_c,
   input  logic signed [VALUE_W-1:0]  req_value_d,
   input  logic signed [VALUE_W-1:0]  req_value_e,
   input  logic                       csr_wr_en,
   input  logic [CSR_W-1:0]           csr_wr_data,
   input  logic                       rsp_stall,
   output logic                       rsp_valid,
   output logic signed [VALUE_W-1:0]  rsp_prop_a,
   output logic signed [VALUE_W-1:0]  rsp_prop_b,
   output logic signed [VALUE_W-1:0]  rsp_prop_c,
   output logic signed [VALUE_W-1:0]  rsp_prop_d,
   output logic signed [VALUE_W-1:0]  rsp_prop_e,
   output logic [REGION_W-1:0]        rsp_region
);

   localparam int ROW_W = $clog2(TABLE_ROWS);

   // table stores
   logic                        row_ok;
   logic                        tbl_wr_en;
   logic [ROW_W-1:0]            tbl_wr_addr;
   logic [VALUE_W-1:0]          alt_rd_data;
   logic [NUM_COLS*VALUE_W-1:0] prop_wr_data;
   logic [NUM_COLS*VALUE_W-1:0] prop_rd_data;
   logic [ROW_W-1:0]            prop_rd_addr;

   // control registers
   logic [CSR_W-1:0]  rows_ff, rows_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic signed [VALUE_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0]          last_ff, last_in;
   logic [ROW_W-1:0]          scan_addr_ff, scan_addr_in;
   logic [ROW_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [VALUE_W-1:0]        prev_key_ff, prev_key_in;
   logic [VALUE_W-1:0]        lo_key_ff, lo_key_in;
   logic [VALUE_W-1:0]        hi_key_ff, hi_key_in;
   logic [ROW_W-1:0]          up_ff, up_in;
   logic [ROW_W-1:0]          lo_row_ff, lo_row_in;
   logic [REGION_W-1:0]       region_ff, region_in;
   atint_row_type             y_lo_ff, y_lo_in;
   atint_row_type             y_hi_ff, y_hi_in;
   logic [VALUE_W-1:0]        y1_ff, y1_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [VALUE_W-1:0]        num_ff, num_in;
   logic [VALUE_W-1:0]        den_ff, den_in;
   logic [PROD_W-1:0]         acc_ff, acc_in;
   atint_row_type             res_ff, res_in;
   atint_row_type             out_row_ff, out_row_in;
   logic [REGION_W-1:0]       out_region_ff, out_region_in;

   // helpers
   logic                      key_gt;
   logic [31:0]               rows_ext;
   logic [VALUE_W:0]          dy, dy_neg, num_wide, den_wide, sum;
   logic [PROD_W-1:0]         prod;

   // two restoring quotient bits per call
   function automatic logic [PROD_W-1:0] div_two(input logic [PROD_W-1:0] a,
                                                 input logic [VALUE_W-1:0] d);
      logic [VALUE_W:0]   t;
      logic [VALUE_W:0]   diff;
      logic               q;
      logic [PROD_W-1:0]  acc;
      acc = a;
      for (int i = 0; i < 2; i++) begin
         t    = {acc[PROD_W-1:VALUE_W], acc[VALUE_W-1]};
         diff = t - {1'b0, d};
         q    = (t >= {1'b0, d});
         acc  = {(q ? diff[VALUE_W-1:0] : t[VALUE_W-1:0]), acc[VALUE_W-2:0], q};
      end
      return acc;
   endfunction

   assign row_ok       = (32'(req_row) < 32'(TABLE_ROWS));
   assign tbl_wr_en    = cmd.load && row_ok;
   assign tbl_wr_addr  = ROW_W'(req_row);
   assign prop_wr_data = {req_value_e, req_value_d, req_value_c, req_value_b, req_value_a};
   assign prop_rd_addr = cmd.rd_hi ? up_ff : lo_row_ff;

   atint_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_ROWS)
   ) u_alt_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (req_altitude),
      .rd_addr (scan_addr_ff),
      .rd_data (alt_rd_data)
   );

   atint_ram #(
      .WIDTH (NUM_COLS * VALUE_W),
      .DEPTH (TABLE_ROWS)
   ) u_prop_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (prop_wr_data),
      .rd_addr (prop_rd_addr),
      .rd_data (prop_rd_data)
   );

   assign key_gt        = ($signed(alt_rd_data) > x_ff);
   assign sts.hit       = cmp_vld_ff && key_gt;
   assign sts.exhausted = cmp_vld_ff && !key_gt && (cmp_idx_ff == last_ff);
   assign sts.clamp     = (region_ff != REGION_INTERP);
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rows_ext = 32'(rows_ff);
   assign dy       = {y_hi_ff[cmd.col][VALUE_W-1], y_hi_ff[cmd.col]}
                   - {y_lo_ff[cmd.col][VALUE_W-1], y_lo_ff[cmd.col]};
   assign dy_neg   = '0 - dy;
   assign num_wide = {x_ff[VALUE_W-1], x_ff} - {lo_key_ff[VALUE_W-1], lo_key_ff};
   assign den_wide = {hi_key_ff[VALUE_W-1], hi_key_ff} - {lo_key_ff[VALUE_W-1], lo_key_ff};
   assign prod     = PROD_W'(mag_ff) * PROD_W'(num_ff);
   assign sum      = neg_ff ? ({y1_ff[VALUE_W-1], y1_ff} - {1'b0, acc_ff[VALUE_W-1:0]})
                            : ({y1_ff[VALUE_W-1], y1_ff} + {1'b0, acc_ff[VALUE_W-1:0]});

   always_comb begin
      rows_in       = csr_wr_en ? csr_wr_data : rows_ff;
      cmp_vld_in    = cmd.scan;
      x_in          = x_ff;
      last_in       = last_ff;
      scan_addr_in  = scan_addr_ff;
      cmp_idx_in    = scan_addr_ff;
      prev_key_in   = prev_key_ff;
      lo_key_in     = lo_key_ff;
      hi_key_in     = hi_key_ff;
      up_in         = up_ff;
      lo_row_in     = lo_row_ff;
      region_in     = region_ff;
      y_lo_in       = y_lo_ff;
      y_hi_in       = y_hi_ff;
      y1_in         = y1_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      acc_in        = acc_ff;
      res_in        = res_ff;
      out_row_in    = out_row_ff;
      out_region_in = out_region_ff;

      if (cmd.start) begin
         x_in         = req_altitude;
         scan_addr_in = '0;
         cmp_vld_in   = 1'b0;
         // zero rows counts as one, more than the table saturates
         if (rows_ff == '0) begin
            last_in = '0;
         end else if (rows_ext > 32'(TABLE_ROWS)) begin
            last_in = ROW_W'(TABLE_ROWS - 1);
         end else begin
            last_in = ROW_W'(rows_ext - 32'd1);
         end
      end

      if (cmd.scan) begin
         scan_addr_in = scan_addr_ff + 1'b1;
         if (cmp_vld_ff) begin
            prev_key_in = alt_rd_data;
         end
         if (sts.hit) begin
            up_in     = cmp_idx_ff;
            hi_key_in = alt_rd_data;
            lo_key_in = prev_key_ff;
            if (cmp_idx_ff == '0) begin
               lo_row_in = '0;
               region_in = REGION_BELOW;
            end else begin
               lo_row_in = cmp_idx_ff - 1'b1;
               region_in = REGION_INTERP;
            end
         end else if (sts.exhausted) begin
            lo_row_in = cmp_idx_ff;
            region_in = REGION_ABOVE;
         end
      end

      if (cmd.cap_lo) begin
         y_lo_in = prop_rd_data;
      end
      if (cmd.cap_hi) begin
         y_hi_in = prop_rd_data;
      end
      if (cmd.cap_clamp) begin
         res_in = prop_rd_data;
      end

      if (cmd.diff) begin
         y1_in  = y_lo_ff[cmd.col];
         neg_in = dy[VALUE_W];
         mag_in = dy[VALUE_W] ? dy_neg[VALUE_W-1:0] : dy[VALUE_W-1:0];
         num_in = num_wide[VALUE_W-1:0];
         den_in = den_wide[VALUE_W-1:0];
      end
      if (cmd.mul) begin
         acc_in = prod;
      end
      if (cmd.div_step) begin
         acc_in = div_two(acc_ff, den_ff);
      end
      if (cmd.store) begin
         res_in[cmd.col] = sum[VALUE_W-1:0];
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         out_row_in    = res_ff;
         out_region_in = region_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_RESET;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      last_ff       <= last_in;
      scan_addr_ff  <= scan_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      prev_key_ff   <= prev_key_in;
      lo_key_ff     <= lo_key_in;
      hi_key_ff     <= hi_key_in;
      up_ff         <= up_in;
      lo_row_ff     <= lo_row_in;
      region_ff     <= region_in;
      y_lo_ff       <= y_lo_in;
      y_hi_ff       <= y_hi_in;
      y1_ff         <= y1_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      acc_ff        <= acc_in;
      res_ff        <= res_in;
      out_row_ff    <= out_row_in;
      out_region_ff <= out_region_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_prop_a = out_row_ff[0];
   assign rsp_prop_b = out_row_ff[1];
   assign rsp_prop_c = out_row_ff[2];
   assign rsp_prop_d = out_row_ff[3];
   assign rsp_prop_e = out_row_ff[4];
   assign rsp_region = out_region_ff;

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan && cmp_vld_ff |-> cmp_idx_ff <= last_ff)
      else $error("scan compared a row beyond the row count");

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |-> den_ff != '0)
      else $error("interpolation span is zero");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> acc_ff[VALUE_W-1:0] <= mag_ff)
      else $error("quotient exceeds the column step");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> acc_ff[PROD_W-1:VALUE_W] < den_ff)
      else $error("remainder not below divisor");

endmodule

>>> dv/atmosphere_table_interpolation_unit_test.sv
`timescale 1ns / 100ps

module atmosphere_table_interpolation_unit_test;
   import atint_pkg::*;

   localparam int TABLE_ROWS  = 64;
   localparam int CYCLE_LIMIT = 2_000_000;

   localparam logic signed [VALUE_W-1:0] MOST  = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] LEAST = 32'sh8000_0000;

   // one request transfer as the driver presents it
   typedef struct {
      logic                      kind;
      logic [ROW_IN_W-1:0]       row;
      logic signed [VALUE_W-1:0] altitude;
      atint_row_type             values;
   } request_type;

   // one response transfer, column 0 is prop_a
   typedef struct {
      atint_row_type        props;
      logic [REGION_W-1:0]  region;
   } answer_type;

   // shadow copy of the altitude table and the row count, plus the queue of
   // responses still owed by the block
   class atint_scoreboard;
      logic signed [VALUE_W-1:0] keys [TABLE_ROWS];
      atint_row_type             cols [TABLE_ROWS];
      logic [CSR_W-1:0]          rows_cfg;
      answer_type                awaited [$];
      int                        loads;
      int                        queries;
      int                        checked;
      int                        mismatches;

      function void clear();
         rows_cfg = ROWS_RESET;
         awaited.delete();
         foreach (keys[i]) begin
            keys[i] = '0;
            cols[i] = '0;
         end
         loads      = 0;
         queries    = 0;
         checked    = 0;
         mismatches = 0;
      endfunction

      // rows actually searched: zero acts as one, large counts saturate
      function int span();
         if (rows_cfg == 0) return 1;
         if (rows_cfg > TABLE_ROWS) return TABLE_ROWS;
         return int'(rows_cfg);
      endfunction

      // exact 64-bit magnitude product, quotient truncated toward zero
      function logic signed [VALUE_W-1:0] lerp(logic signed [VALUE_W-1:0] x,
                                               logic signed [VALUE_W-1:0] x1,
                                               logic signed [VALUE_W-1:0] x2,
                                               logic signed [VALUE_W-1:0] y1,
                                               logic signed [VALUE_W-1:0] y2);
         longint            dy;
         longint            total;
         logic [PROD_W-1:0] num;
         logic [PROD_W-1:0] den;
         logic [PROD_W-1:0] mag;
         logic [PROD_W-1:0] quot;
         dy  = longint'(y2) - longint'(y1);
         num = PROD_W'(longint'(x) - longint'(x1));
         den = PROD_W'(longint'(x2) - longint'(x1));
         mag = (dy < 0) ? PROD_W'(-dy) : PROD_W'(dy);
         if (den == 0) return y1;
         quot  = (mag * num) / den;
         total = (dy < 0) ? longint'(y1) - longint'(quot) : longint'(y1) + longint'(quot);
         return VALUE_W'(total);
      endfunction

      function answer_type predict(logic signed [VALUE_W-1:0] x);
         answer_type a;
         int         n;
         int         hi;
         int         lo;
         n  = span();
         hi = n;
         // first row whose key lies strictly above the query point
         for (int i = n - 1; i >= 0; i--)
            if (keys[i] > x) hi = i;
         if (hi == n) begin
            lo       = n - 1;
            a.region = REGION_ABOVE;
         end else if (hi == 0) begin
            lo       = 0;
            a.region = REGION_BELOW;
         end else begin
            lo       = hi - 1;
            a.region = REGION_INTERP;
         end
         for (int c = 0; c < NUM_COLS; c++)
            if (a.region == REGION_INTERP)
               a.props[c] = lerp(x, keys[lo], keys[hi], cols[lo][c], cols[hi][c]);
            else
               a.props[c] = cols[lo][c];
         return a;
      endfunction

      function void note_request(request_type r);
         if (r.kind == KIND_LOAD) begin
            keys[r.row] = r.altitude;
            cols[r.row] = r.values;
            loads++;
         end else begin
            awaited.insert(awaited.size(), predict(r.altitude));
            queries++;
         end
      endfunction

      function void fault(string what, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected 0x%08h, got 0x%08h", what, want, got);
      endfunction

      function void check_result(answer_type got);
         answer_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response with no query outstanding");
            return;
         end
         want = awaited.pop_front();
         checked++;
         for (int c = 0; c < NUM_COLS; c++)
            if (got.props[c] !== want.props[c])
               fault($sformatf("prop_%c", 8'h61 + c), want.props[c], got.props[c]);
         if (got.region !== want.region)
            fault("region", VALUE_W'(want.region), VALUE_W'(got.region));
      endfunction

      function void close();
         if (awaited.size() != 0) begin
            mismatches += awaited.size();
            $display("%0d responses never arrived", awaited.size());
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset        = 1'b1;
   logic                       req_valid    = 1'b0;
   logic                       req_stall;
   logic                       req_kind     = KIND_LOAD;
   logic [ROW_IN_W-1:0]        req_row      = '0;
   logic signed [VALUE_W-1:0]  req_altitude = '0;
   logic signed [VALUE_W-1:0]  req_value_a  = '0;
   logic signed [VALUE_W-1:0]  req_value_b  = '0;
   logic signed [VALUE_W-1:0]  req_value_c  = '0;
   logic signed [VALUE_W-1:0]  req_value_d  = '0;
   logic signed [VALUE_W-1:0]  req_value_e  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall    = 1'b0;
   logic signed [VALUE_W-1:0]  rsp_prop_a;
   logic signed [VALUE_W-1:0]  rsp_prop_b;
   logic signed [VALUE_W-1:0]  rsp_prop_c;
   logic signed [VALUE_W-1:0]  rsp_prop_d;
   logic signed [VALUE_W-1:0]  rsp_prop_e;
   logic [REGION_W-1:0]        rsp_region;
   logic                       csr_wr_en    = 1'b0;
   logic [CSR_W-1:0]           csr_wr_data  = '0;

   atint_scoreboard sb = new;
   int send_idle_pct = 30;
   int recv_idle_pct = 55;
   int cycle_count   = 0;

   atmosphere_table_interpolation_unit #(
      .TABLE_ROWS(TABLE_ROWS)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_row      (req_row),
      .req_altitude (req_altitude),
      .req_value_a  (req_value_a),
      .req_value_b  (req_value_b),
      .req_value_c  (req_value_c),
      .req_value_d  (req_value_d),
      .req_value_e  (req_value_e),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prop_a   (rsp_prop_a),
      .rsp_prop_b   (rsp_prop_b),
      .rsp_prop_c   (rsp_prop_c),
      .rsp_prop_d   (rsp_prop_d),
      .rsp_prop_e   (rsp_prop_e),
      .rsp_region   (rsp_region),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   // 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // watchdog: a hung handshake or a lost response ends up here
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
   end

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   // response monitor: a transfer is valid high and stall low at the rising edge
   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.props  = {rsp_prop_e, rsp_prop_d, rsp_prop_c, rsp_prop_b, rsp_prop_a};
         got.region = rsp_region;
         sb.check_result(got);
      end
   end

   // random word with a fair share of the extremes
   function automatic logic [VALUE_W-1:0] any_word();
      case ($urandom_range(9))
         0:       return MOST;
         1:       return LEAST;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type load_item(logic [ROW_IN_W-1:0] row,
                                             logic signed [VALUE_W-1:0] key,
                                             logic [VALUE_W-1:0] a, logic [VALUE_W-1:0] b,
                                             logic [VALUE_W-1:0] c, logic [VALUE_W-1:0] d,
                                             logic [VALUE_W-1:0] e);
      request_type r;
      r.kind     = KIND_LOAD;
      r.row      = row;
      r.altitude = key;
      r.values   = {e, d, c, b, a};
      return r;
   endfunction

   // row and value fields are don't-care on a query, so fill them with noise
   function automatic request_type query_item(logic signed [VALUE_W-1:0] x);
      request_type r;
      r.kind     = KIND_QUERY;
      r.row      = ROW_IN_W'($urandom);
      r.altitude = x;
      r.values   = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
   endfunction

   // query points aimed at the current table: on keys, just either side,
   // inside a segment, off both ends, the two extremes, plus plain noise
   function automatic request_type make_query(int n);
      int                        i;
      longint                    gap;
      logic signed [VALUE_W-1:0] lo;
      logic signed [VALUE_W-1:0] hi;
      logic signed [VALUE_W-1:0] x;
      i  = $urandom_range(n - 1);
      lo = sb.keys[(i == 0) ? 0 : i - 1];
      hi = sb.keys[i];
      case ($urandom_range(9))
         0:       x = $urandom;
         1:       x = $urandom_range(1) ? MOST : LEAST;
         2, 3:    x = hi;
         4, 5, 6: begin
            gap = longint'(hi) - longint'(lo);
            if (gap > 0)
               x = VALUE_W'(longint'(lo) + longint'($urandom_range(32'(gap - 1))));
            else
               x = hi;
         end
         7:       x = $urandom_range(1) ? hi - 1 : hi + 1;
         8:       x = sb.keys[0] - $urandom_range(1000);
         default: x = sb.keys[n - 1] + $urandom_range(1000);
      endcase
      return query_item(x);
   endfunction

   // mostly refresh a row under its old key so the table stays ordered
   function automatic request_type make_load();
      logic [ROW_IN_W-1:0] row;
      row = ROW_IN_W'($urandom);
      return load_item(row, ($urandom_range(99) < 70) ? sb.keys[row] : any_word(),
                       any_word(), any_word(), any_word(), any_word(), any_word());
   endfunction

   // entered and left on a falling edge; valid stays high between
   // back-to-back transfers
   task automatic put_request(input request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_kind     <= r.kind;
      req_row      <= r.row;
      req_altitude <= r.altitude;
      req_value_a  <= r.values[0];
      req_value_b  <= r.values[1];
      req_value_c  <= r.values[2];
      req_value_d  <= r.values[3];
      req_value_e  <= r.values[4];
      req_valid    <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      @(negedge clock);
   endtask

   // wait for every owed response, then let a trailing load settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_rows(input logic [CSR_W-1:0] setting);
      csr_wr_data <= setting;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.rows_cfg = setting;
   endtask

   // new row count, a fresh table over every searched row, then a random mix
   task automatic run_phase(input logic [CSR_W-1:0] setting, input int items);
      int keyq [$];
      int n;
      int base;
      drain();
      write_rows(setting);
      n = sb.span();
      if ($urandom_range(1)) begin
         repeat (n) keyq.insert(keyq.size(), int'($urandom));
      end else begin
         // tight spacing gives repeated keys and tiny segments
         base = int'($urandom);
         repeat (n) begin
            keyq.insert(keyq.size(), base);
            base += $urandom_range(400);
         end
      end
      // the odd table is left unsorted
      if ($urandom_range(99) < 85) keyq.sort();
      foreach (keyq[i])
         put_request(load_item(ROW_IN_W'(i), keyq[i], any_word(), any_word(), any_word(),
                               any_word(), any_word()));
      repeat (items) begin
         if ($urandom_range(99) < 65)
            put_request(make_query(n));
         else
            put_request(make_load());
      end
   endtask

   initial begin
      logic [CSR_W-1:0] plan [9];
      plan = '{7'd0, 7'd64, 7'd1, 7'd127, CSR_W'($urandom_range(63, 3)), 7'd2, 7'd64,
               CSR_W'($urandom_range(126, 65)), CSR_W'($urandom_range(63, 3))};
      sb.clear();
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // two rows spanning the whole key range with extreme columns
      write_rows(7'd2);
      put_request(load_item(ROW_IN_W'(0), LEAST, LEAST, MOST, 0, -1, 1));
      put_request(load_item(ROW_IN_W'(1), MOST, MOST, LEAST, -1, 0, LEAST));
      put_request(query_item(LEAST));
      put_request(query_item(0));
      put_request(query_item(-1));
      put_request(query_item(MOST - 1));
      put_request(query_item(MOST));

      // three narrow rows: below, on a key, inside, above
      drain();
      write_rows(7'd3);
      put_request(load_item(ROW_IN_W'(0), -256, 100, -100, 7, MOST, LEAST));
      put_request(load_item(ROW_IN_W'(1), 0, 200, -300, 7, LEAST, MOST));
      put_request(load_item(ROW_IN_W'(2), 256, -50, 1000, 8, 0, 0));
      put_request(query_item(-257));
      put_request(query_item(-256));
      put_request(query_item(100));
      put_request(query_item(255));
      put_request(query_item(256));
      put_request(query_item(LEAST));

      // keys out of order: the scan still stops at the first larger key
      put_request(load_item(ROW_IN_W'(1), -1000, 1, 2, 3, 4, 5));
      put_request(query_item(-500));
      put_request(query_item(-100));

      // random phases, idling pattern changes every three of them
      for (int p = 0; p < 9; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         run_phase(plan[p], 160);
      end

      // after the last query, idle on for any stray responses
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      sb.close();

      $display("%0d loads and %0d queries transferred, %0d responses checked",
               sb.loads, sb.queries, sb.checked);
      $display("row counts from 0 to 127 used, with sorted, dense and unsorted tables");
      if (sb.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/atint_pkg.sv
rtl/core/atint_ram.sv
rtl/core/atint_ctrl.sv
rtl/core/atint_dp.sv
rtl/core/atmosphere_table_interpolation_unit.sv
dv/atmosphere_table_interpolation_unit_test.sv
